FILE: hw/rtl/gwf_pkg.sv
// Shared types and constants for the guarded watchdog feeder.
// Depends on nothing; imported by gwf_step and guarded_watchdog_feeder.
package gwf_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned REQ_W    = 3;
    localparam int unsigned OP_W     = 3;
    localparam int unsigned KIND_W   = 4;

    localparam logic [PERIOD_W-1:0] FEED_PERIOD_RESET = 16'd1000;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ARM      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POLL     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_BEGIN    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_END      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PROGRESS = 3'd4;

    // Operation and progress codes meaning "none"
    localparam logic [OP_W-1:0]   OP_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NONE = 4'd0;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [TIME_W-1:0] now_ms;
        logic [OP_W-1:0]   op_code;
        logic [KIND_W-1:0] progress_kind;
        logic [TIME_W-1:0] progress_amount;
        logic              hw_wdg_running;
    } t_req;

    typedef struct packed {
        logic              enabled;
        logic              fault;
        logic [OP_W-1:0]   open_op;
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] amount;
        logic [TIME_W-1:0] feed_stamp;
        logic [TIME_W-1:0] progress_stamp;
        logic [TIME_W-1:0] feed_tally;
    } t_state;

    typedef struct packed {
        logic accepted;
        logic restart_pulse;
    } t_flags;

endpackage

FILE: hw/rtl/gwf_step.sv
// Next-state and result logic for one supervisor request.
// Depends on gwf_pkg for the request, state and flag types.
module gwf_step
    import gwf_pkg::*;
(
    input  t_req                i_req,
    input  t_state              i_state,
    input  logic [PERIOD_W-1:0] i_feed_period,
    output t_state              o_next_state,
    output t_flags              o_flags
);

    logic              ready;
    logic              no_open;
    logic              op_valid;
    logic [TIME_W-1:0] elapsed;
    logic              poll_due;

    assign ready    = i_state.enabled && !i_state.fault;
    assign no_open  = (i_state.open_op == OP_NONE);
    assign op_valid = (i_req.op_code != OP_NONE);
    assign elapsed  = i_req.now_ms - i_state.feed_stamp;
    assign poll_due = (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, i_feed_period});

    always_comb begin
        o_next_state = i_state;
        o_flags      = '0;
        unique case (i_req.req_type)
            REQ_ARM: begin
                o_next_state          = '0;
                o_flags.restart_pulse = 1'b1;
                if (i_req.hw_wdg_running) begin
                    o_next_state.enabled    = 1'b1;
                    o_next_state.feed_stamp = i_req.now_ms;
                    o_next_state.feed_tally = 32'd1;
                    o_flags.accepted        = 1'b1;
                end else begin
                    o_next_state.fault = 1'b1;
                end
            end
            REQ_POLL: begin
                o_flags.accepted = 1'b1;
                if (ready && no_open && poll_due) begin
                    if (i_req.hw_wdg_running) begin
                        o_flags.restart_pulse   = 1'b1;
                        o_next_state.feed_stamp = i_req.now_ms;
                        o_next_state.feed_tally = i_state.feed_tally + 32'd1;
                    end else begin
                        o_flags.accepted     = 1'b0;
                        o_next_state.enabled = 1'b0;
                        o_next_state.fault   = 1'b1;
                    end
                end
            end
            REQ_BEGIN: begin
                if (ready && op_valid && no_open) begin
                    if (i_req.hw_wdg_running) begin
                        o_flags.restart_pulse   = 1'b1;
                        o_flags.accepted        = 1'b1;
                        o_next_state.feed_stamp = i_req.now_ms;
                        o_next_state.feed_tally = i_state.feed_tally + 32'd1;
                        o_next_state.open_op    = i_req.op_code;
                    end else begin
                        o_next_state.enabled = 1'b0;
                        o_next_state.fault   = 1'b1;
                    end
                end else begin
                    o_next_state.fault = 1'b1;
                end
            end
            REQ_END: begin
                if (ready && op_valid && (i_state.open_op == i_req.op_code)) begin
                    // The operation closes even when the feed fails.
                    o_next_state.open_op = OP_NONE;
                    if (i_req.hw_wdg_running) begin
                        o_flags.restart_pulse   = 1'b1;
                        o_flags.accepted        = 1'b1;
                        o_next_state.feed_stamp = i_req.now_ms;
                        o_next_state.feed_tally = i_state.feed_tally + 32'd1;
                    end else begin
                        o_next_state.enabled = 1'b0;
                        o_next_state.fault   = 1'b1;
                    end
                end else begin
                    o_next_state.fault = 1'b1;
                end
            end
            REQ_PROGRESS: begin
                if (ready && (i_req.progress_kind != KIND_NONE) && no_open) begin
                    if (i_req.hw_wdg_running) begin
                        o_flags.restart_pulse       = 1'b1;
                        o_flags.accepted            = 1'b1;
                        o_next_state.feed_stamp     = i_req.now_ms;
                        o_next_state.feed_tally     = i_state.feed_tally + 32'd1;
                        o_next_state.kind           = i_req.progress_kind;
                        o_next_state.amount         = i_req.progress_amount;
                        o_next_state.progress_stamp = i_req.now_ms;
                    end else begin
                        o_next_state.enabled = 1'b0;
                        o_next_state.fault   = 1'b1;
                    end
                end else begin
                    o_next_state.fault = 1'b1;
                end
            end
            default: begin
                // Unknown request: state unchanged, rejected, no restart.
            end
        endcase
    end

endmodule

FILE: hw/rtl/guarded_watchdog_feeder.sv
// Top level of the guarded watchdog feeder: request register, supervisor
// state and result register. Depends on gwf_pkg and gwf_step.
//
// The block supervises a hardware watchdog. Each request beat (arm, poll,
// begin operation, end operation or note progress) carries the current
// millisecond time and the watchdog's running status, and produces exactly
// one result beat: accepted, a restart pulse and a snapshot of the
// supervisor state after the request. A poll feeds the watchdog when the
// supervisor is enabled, not faulted, no operation is open and at least
// feed_period_ms milliseconds have passed since the last feed (time wraps
// modulo 2^32). Invalid begin, end and progress requests latch a sticky
// fault, as does any feed attempted while the hardware watchdog is stopped,
// which also clears the enable flag. Only an arm clears the fault. The
// block takes one request per clock cycle when the result side keeps up;
// a request beat is registered on acceptance and its result is loaded into
// the result register once the result side can take it, from where the
// result beat is offered until it is taken. The whole request
// is decided by one short pass of logic (a 32-bit subtract and compare and
// a 32-bit increment) between the request register and the state and
// result registers. The feed period register (reset 1000) is written
// through i_cfg_we and i_cfg_wdata and should only be changed while no
// requests are in flight.
module guarded_watchdog_feeder
    import gwf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_we,
    input  logic [PERIOD_W-1:0] i_cfg_wdata,

    input  logic                i_valid,
    output logic                o_ready,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [TIME_W-1:0]   i_now_ms,
    input  logic [OP_W-1:0]     i_op_code,
    input  logic [KIND_W-1:0]   i_progress_kind,
    input  logic [TIME_W-1:0]   i_progress_amount,
    input  logic                i_hw_wdg_running,

    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_accepted,
    output logic                o_restart_pulse,
    output logic                o_is_enabled,
    output logic                o_fault_latched,
    output logic [OP_W-1:0]     o_active_operation,
    output logic [KIND_W-1:0]   o_last_progress_kind,
    output logic [TIME_W-1:0]   o_last_progress_amount,
    output logic [TIME_W-1:0]   o_last_feed_time,
    output logic [TIME_W-1:0]   o_last_progress_time,
    output logic [TIME_W-1:0]   o_feed_total
);

    logic [PERIOD_W-1:0] r_feed_period;

    logic   r_req_valid;
    t_req   r_req;
    t_state r_state;
    t_state n_state;
    t_flags r_flags;
    t_flags n_flags;
    logic   r_out_valid;

    logic   out_load;
    logic   advance;

    // The result register may take a new beat when empty or being drained.
    assign out_load = !r_out_valid || i_ready;
    // A request leaves the request register when the result side can take it.
    assign advance  = r_req_valid && out_load;
    // The request register is free when empty or emptying this cycle.
    assign o_ready  = !r_req_valid || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feed_period <= FEED_PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_feed_period <= i_cfg_wdata;
        end
    end

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (o_ready) begin
            r_req_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req.req_type        <= i_req_type;
            r_req.now_ms          <= i_now_ms;
            r_req.op_code         <= i_op_code;
            r_req.progress_kind   <= i_progress_kind;
            r_req.progress_amount <= i_progress_amount;
            r_req.hw_wdg_running  <= i_hw_wdg_running;
        end
    end

    gwf_step u_step (
        .i_req         (r_req),
        .i_state       (r_state),
        .i_feed_period (r_feed_period),
        .o_next_state  (n_state),
        .o_flags       (n_flags)
    );

    // Supervisor state. It only moves when a result beat is loaded, so
    // while a result waits it still shows that result's snapshot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_flags <= n_flags;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_accepted             = r_flags.accepted;
    assign o_restart_pulse        = r_flags.restart_pulse;
    assign o_is_enabled           = r_state.enabled;
    assign o_fault_latched        = r_state.fault;
    assign o_active_operation     = r_state.open_op;
    assign o_last_progress_kind   = r_state.kind;
    assign o_last_progress_amount = r_state.amount;
    assign o_last_feed_time       = r_state.feed_stamp;
    assign o_last_progress_time   = r_state.progress_stamp;
    assign o_feed_total           = r_state.feed_tally;

endmodule

FILE: sim/guarded_watchdog_feeder_tb.sv
// Self-checking testbench for guarded_watchdog_feeder: a request sender, a result
// checker and a predictor of the supervisor state, run through several feed periods.
// Depends on gwf_pkg and the guarded_watchdog_feeder RTL only.
module guarded_watchdog_feeder_tb;
    import gwf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned IDLE_PCT    = 21;
    localparam int unsigned REPORT_MAX  = 10;
    localparam int unsigned HOLD_CYCLES = 300;

    localparam logic [REQ_W-1:0]    REQ_LAST_CODE = '1;
    localparam logic [OP_W-1:0]     OP_LAST       = '1;
    localparam logic [KIND_W-1:0]   KIND_LAST     = '1;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN    = 16'd1;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX    = 16'd64999;

    // One result beat as the block should present it.
    typedef struct packed {
        t_flags flags;
        t_state snap;
    } t_outcome;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [PERIOD_W-1:0] i_cfg_wdata = '0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [REQ_W-1:0]    i_req_type = REQ_POLL;
    logic [TIME_W-1:0]   i_now_ms = '0;
    logic [OP_W-1:0]     i_op_code = OP_NONE;
    logic [KIND_W-1:0]   i_progress_kind = KIND_NONE;
    logic [TIME_W-1:0]   i_progress_amount = '0;
    logic                i_hw_wdg_running = 1'b0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic                o_accepted;
    logic                o_restart_pulse;
    logic                o_is_enabled;
    logic                o_fault_latched;
    logic [OP_W-1:0]     o_active_operation;
    logic [KIND_W-1:0]   o_last_progress_kind;
    logic [TIME_W-1:0]   o_last_progress_amount;
    logic [TIME_W-1:0]   o_last_feed_time;
    logic [TIME_W-1:0]   o_last_progress_time;
    logic [TIME_W-1:0]   o_feed_total;

    guarded_watchdog_feeder dut (.*);

    // Predicted supervisor state and feed period, updated as each request beat
    // is accepted and as each period write takes effect.
    t_state              sup_state;
    logic [PERIOD_W-1:0] feed_period;
    t_outcome            pending_outcomes[$];
    t_outcome            oldest;

    // The millisecond clock that the random traffic walks forward.
    logic [TIME_W-1:0]   clock_ms;

    // When steady is set neither side idles; hold_left makes the receiver hold
    // off for that many cycles, counted down in the receiver process itself.
    bit                  steady = 1'b0;
    int unsigned         hold_left = 0;

    int unsigned         cycle_count = 0;
    int unsigned         n_requests = 0;
    int unsigned         n_results = 0;
    int unsigned         n_feeds = 0;
    int unsigned         n_faulted = 0;
    int unsigned         n_fail = 0;

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A feed only succeeds on an enabled, healthy supervisor whose hardware
    // watchdog is running; any other attempt drops the enable flag and
    // latches the fault.
    function automatic logic feed_attempt(input logic [TIME_W-1:0] now, input logic hw_on);
        if (!sup_state.enabled || sup_state.fault || !hw_on) begin
            sup_state.enabled = 1'b0;
            sup_state.fault   = 1'b1;
            return 1'b0;
        end
        sup_state.feed_stamp = now;
        sup_state.feed_tally = sup_state.feed_tally + 32'd1;
        return 1'b1;
    endfunction

    // Applies one request to the predicted state and returns the result beat
    // it should produce. The restart pulse follows a successful feed except
    // on arm, which always restarts the hardware watchdog.
    function automatic t_outcome supervise(input t_req r);
        t_outcome          res;
        logic              live;
        logic              ok;
        logic              pulse;
        logic [TIME_W-1:0] since;
        live  = sup_state.enabled && !sup_state.fault;
        since = r.now_ms - sup_state.feed_stamp;
        ok    = 1'b0;
        pulse = 1'b0;
        case (r.req_type)
            REQ_ARM: begin
                sup_state = '0;
                pulse     = 1'b1;
                if (r.hw_wdg_running) begin
                    sup_state.enabled    = 1'b1;
                    sup_state.feed_stamp = r.now_ms;
                    sup_state.feed_tally = 32'd1;
                    ok = 1'b1;
                end else begin
                    sup_state.fault = 1'b1;
                end
            end
            REQ_POLL: begin
                ok = 1'b1;
                if (live && sup_state.open_op == OP_NONE &&
                    since >= TIME_W'(feed_period)) begin
                    ok    = feed_attempt(r.now_ms, r.hw_wdg_running);
                    pulse = ok;
                end
            end
            REQ_BEGIN: begin
                if (live && r.op_code != OP_NONE && sup_state.open_op == OP_NONE) begin
                    ok    = feed_attempt(r.now_ms, r.hw_wdg_running);
                    pulse = ok;
                end
                if (ok) begin
                    sup_state.open_op = r.op_code;
                end else begin
                    sup_state.fault = 1'b1;
                end
            end
            REQ_END: begin
                // The operation is closed even when the feed that follows fails.
                if (live && r.op_code != OP_NONE && sup_state.open_op == r.op_code) begin
                    sup_state.open_op = OP_NONE;
                    ok    = feed_attempt(r.now_ms, r.hw_wdg_running);
                    pulse = ok;
                end else begin
                    sup_state.fault = 1'b1;
                end
            end
            REQ_PROGRESS: begin
                if (live && r.progress_kind != KIND_NONE && sup_state.open_op == OP_NONE) begin
                    ok    = feed_attempt(r.now_ms, r.hw_wdg_running);
                    pulse = ok;
                end
                if (ok) begin
                    sup_state.kind           = r.progress_kind;
                    sup_state.amount         = r.progress_amount;
                    sup_state.progress_stamp = r.now_ms;
                end else begin
                    sup_state.fault = 1'b1;
                end
            end
            default: begin
                // Unknown request codes leave the state alone and are rejected.
            end
        endcase
        res.flags.accepted      = ok;
        res.flags.restart_pulse = pulse;
        res.snap                = sup_state;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request beat and returns at the edge where it is taken, with
    // valid still high, so that the next call can present its beat at once.
    // Every caller follows up straight away with another call or a drain.
    task automatic offer_request(input t_req r);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_valid           <= 1'b1;
        i_req_type        <= r.req_type;
        i_now_ms          <= r.now_ms;
        i_op_code         <= r.op_code;
        i_progress_kind   <= r.progress_kind;
        i_progress_amount <= r.progress_amount;
        i_hw_wdg_running  <= r.hw_wdg_running;
        do @(posedge i_clk); while (!o_ready);
        pending_outcomes.push_back(supervise(r));
        n_requests++;
    endtask

    // Drops valid and waits until every predicted result has been checked.
    // Each request gives exactly one result, so a short settle is enough.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // The period register is only touched once the block has gone quiet.
    task automatic write_feed_period(input logic [PERIOD_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        feed_period = value;
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_req make_req(input logic [REQ_W-1:0] req_type,
                                      input logic [TIME_W-1:0] now,
                                      input logic [OP_W-1:0] op,
                                      input logic [KIND_W-1:0] kind,
                                      input logic [TIME_W-1:0] amount,
                                      input logic hw_on);
        t_req r;
        r.req_type        = req_type;
        r.now_ms          = now;
        r.op_code         = op;
        r.progress_kind   = kind;
        r.progress_amount = amount;
        r.hw_wdg_running  = hw_on;
        return r;
    endfunction

    // Moves the traffic clock on: mostly short steps and steps close to the
    // feed period, now and then a jump to anywhere in the 32-bit range.
    task automatic advance_clock();
        int unsigned       pick;
        logic [TIME_W-1:0] span;
        span = TIME_W'(feed_period);
        pick = $urandom_range(99);
        if (pick < 35) begin
            clock_ms = clock_ms + $urandom_range(span / 4);
        end else if (pick < 75) begin
            clock_ms = clock_ms + span + $urandom_range(4) - 32'd2;
        end else if (pick < 97) begin
            clock_ms = clock_ms + $urandom_range(2 * span);
        end else begin
            clock_ms = $urandom();
        end
    endtask

    // Builds a request that mostly follows a sensible protocol from the
    // present predicted state, with some noise mixed in.
    function automatic t_req shaped_request();
        t_req        r;
        int unsigned pick;
        r = make_req(REQ_POLL, clock_ms, OP_W'($urandom_range(OP_LAST, 1)),
                     KIND_W'($urandom_range(KIND_LAST, 1)), $urandom(),
                     $urandom_range(99) >= 4);
        pick = $urandom_range(99);
        if (pick < 8) begin
            r.req_type       = REQ_W'($urandom_range(REQ_LAST_CODE, 0));
            r.op_code        = OP_W'($urandom_range(OP_LAST, 0));
            r.progress_kind  = KIND_W'($urandom_range(KIND_LAST, 0));
            r.hw_wdg_running = 1'($urandom_range(1));
        end else if (!sup_state.enabled || sup_state.fault) begin
            r.req_type = REQ_ARM;
        end else if (sup_state.open_op != OP_NONE) begin
            if (pick < 55) begin
                r.req_type = REQ_END;
                if (pick >= 12) begin
                    r.op_code = sup_state.open_op;
                end
            end
        end else if (pick < 35) begin
            r.req_type = REQ_BEGIN;
        end else if (pick < 60) begin
            r.req_type = REQ_PROGRESS;
        end
        return r;
    endfunction

    task automatic run_shaped(input int unsigned count);
        repeat (count) begin
            advance_clock();
            offer_request(shaped_request());
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (got !== want) begin
            n_fail++;
            if (n_fail <= REPORT_MAX) begin
                $display("result %0d: %s expected %h, got %h", n_results, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_outcomes.size() == 0) begin
                n_fail++;
                if (n_fail <= REPORT_MAX) begin
                    $display("result beat arrived with no request outstanding");
                end
            end else begin
                oldest = pending_outcomes.pop_front();
                check_field("accepted", TIME_W'(oldest.flags.accepted),
                            TIME_W'(o_accepted));
                check_field("restart_pulse", TIME_W'(oldest.flags.restart_pulse),
                            TIME_W'(o_restart_pulse));
                check_field("is_enabled", TIME_W'(oldest.snap.enabled),
                            TIME_W'(o_is_enabled));
                check_field("fault_latched", TIME_W'(oldest.snap.fault),
                            TIME_W'(o_fault_latched));
                check_field("active_operation", TIME_W'(oldest.snap.open_op),
                            TIME_W'(o_active_operation));
                check_field("last_progress_kind", TIME_W'(oldest.snap.kind),
                            TIME_W'(o_last_progress_kind));
                check_field("last_progress_amount", oldest.snap.amount,
                            o_last_progress_amount);
                check_field("last_feed_time", oldest.snap.feed_stamp, o_last_feed_time);
                check_field("last_progress_time", oldest.snap.progress_stamp,
                            o_last_progress_time);
                check_field("feed_total", oldest.snap.feed_tally, o_feed_total);
                if (oldest.flags.restart_pulse) begin
                    n_feeds++;
                end
                if (oldest.snap.fault) begin
                    n_faulted++;
                end
            end
            n_results++;
        end
    end

    // Watchdog on the testbench itself.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out with %0d results outstanding", pending_outcomes.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walks through every request kind and each awkward corner, using the
    // reset feed period of 1000 ms.
    task automatic test_directed();
        logic [TIME_W-1:0] t0;
        t0 = 32'hFFFF_FE00;
        // Poll and begin on a supervisor that has never been armed.
        offer_request(make_req(REQ_POLL, 32'd5000, OP_NONE, KIND_NONE, '0, 1'b1));
        offer_request(make_req(REQ_BEGIN, 32'd5001, 3'd1, KIND_NONE, '0, 1'b1));
        // Arm with the hardware watchdog stopped, then arm properly near the wrap.
        offer_request(make_req(REQ_ARM, 32'd6000, OP_NONE, KIND_NONE, '0, 1'b0));
        offer_request(make_req(REQ_ARM, t0, OP_NONE, KIND_NONE, '0, 1'b1));
        // One millisecond short of the period, then exactly on it, then a period later; all past the wrap.
        offer_request(make_req(REQ_POLL, t0 + 32'd999, OP_NONE, KIND_NONE, '0, 1'b1));
        offer_request(make_req(REQ_POLL, t0 + 32'd1000, OP_NONE, KIND_NONE, '0, 1'b1));
        offer_request(make_req(REQ_POLL, t0 + 32'd2000, OP_NONE, KIND_NONE, '0, 1'b1));
        // An open operation blocks periodic feeds and progress notes.
        offer_request(make_req(REQ_BEGIN, t0 + 32'd2001, OP_LAST, KIND_NONE, '0, 1'b1));
        offer_request(make_req(REQ_POLL, t0 + 32'd9000, OP_NONE, KIND_NONE, '0, 1'b1));
        offer_request(make_req(REQ_PROGRESS, t0 + 32'd9001, OP_NONE, 4'd3, 32'd7, 1'b1));
        // Once faulted even a matching end is refused.
        offer_request(make_req(REQ_END, t0 + 32'd9002, OP_LAST, KIND_NONE, '0, 1'b1));
        // Begin with no operation code.
        offer_request(make_req(REQ_ARM, 32'd0, OP_NONE, KIND_NONE, '0, 1'b1));
        offer_request(make_req(REQ_BEGIN, 32'd1, OP_NONE, KIND_NONE, '0, 1'b1));
        // End naming a different operation from the open one.
        offer_request(make_req(REQ_ARM, 32'd10, OP_NONE, KIND_NONE, '0, 1'b1));
        offer_request(make_req(REQ_BEGIN, 32'd20, 3'd3, KIND_NONE, '0, 1'b1));
        offer_request(make_req(REQ_END, 32'd21, 3'd5, KIND_NONE, '0, 1'b1));
        // A valid end whose feed fails still closes the operation.
        offer_request(make_req(REQ_ARM, 32'd30, OP_NONE, KIND_NONE, '0, 1'b1));
        offer_request(make_req(REQ_BEGIN, 32'd40, 3'd3, KIND_NONE, '0, 1'b1));
        offer_request(make_req(REQ_END, 32'd50, 3'd3, KIND_NONE, '0, 1'b0));
        // Progress with no kind, then the largest kind and amount at the top of time.
        offer_request(make_req(REQ_ARM, 32'd60, OP_NONE, KIND_NONE, '0, 1'b1));
        offer_request(make_req(REQ_PROGRESS, 32'd61, OP_NONE, KIND_NONE, 32'd9, 1'b1));
        offer_request(make_req(REQ_ARM, 32'd70, OP_LAST, KIND_LAST, '1, 1'b1));
        offer_request(make_req(REQ_PROGRESS, '1, OP_NONE, KIND_LAST, '1, 1'b1));
        // End with nothing open, after re-arming.
        offer_request(make_req(REQ_ARM, 32'd80, OP_NONE, KIND_NONE, '0, 1'b1));
        offer_request(make_req(REQ_END, 32'd81, 3'd1, KIND_NONE, '0, 1'b1));
        // A due poll while the hardware watchdog has stopped.
        offer_request(make_req(REQ_ARM, 32'd90, OP_NONE, KIND_NONE, '0, 1'b1));
        offer_request(make_req(REQ_POLL, 32'd1090, OP_NONE, KIND_NONE, '0, 1'b0));
        // The unused request codes, with every other field at its top value.
        for (int code = int'(REQ_PROGRESS) + 1; code <= int'(REQ_LAST_CODE); code++) begin
            offer_request(make_req(REQ_W'(code), '1, OP_LAST, KIND_LAST, '1, 1'b1));
        end
        drain_results();
    endtask

    // Checks the due-feed boundary at both extremes of the period and two
    // values in between, from a random starting time.
    task automatic test_feed_period();
        logic [PERIOD_W-1:0] periods [4];
        logic [TIME_W-1:0]   span;
        periods = '{PERIOD_MIN, PERIOD_MAX, 16'd16, FEED_PERIOD_RESET};
        foreach (periods[i]) begin
            write_feed_period(periods[i]);
            span     = TIME_W'(feed_period);
            clock_ms = $urandom();
            offer_request(make_req(REQ_ARM, clock_ms, OP_NONE, KIND_NONE, '0, 1'b1));
            offer_request(make_req(REQ_POLL, clock_ms + span - 32'd1, OP_NONE, KIND_NONE,
                                   '0, 1'b1));
            offer_request(make_req(REQ_POLL, clock_ms + span, OP_NONE, KIND_NONE,
                                   '0, 1'b1));
            offer_request(make_req(REQ_POLL, clock_ms + span, OP_NONE, KIND_NONE,
                                   '0, 1'b1));
            offer_request(make_req(REQ_POLL, clock_ms + 32'd2 * span + 32'd1, OP_NONE,
                                   KIND_NONE, '0, 1'b1));
        end
        drain_results();
    endtask

    // A long stretch with no idling on either side, at the shortest period so
    // that nearly every poll feeds.
    task automatic test_back_to_back();
        write_feed_period(PERIOD_MIN);
        steady = 1'b1;
        run_shaped(150);
        drain_results();
        steady = 1'b0;
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so
    // the block fills and must stall its request side.
    task automatic test_backpressure();
        write_feed_period(PERIOD_W'($urandom_range(PERIOD_MAX, PERIOD_MIN)));
        hold_left = HOLD_CYCLES;
        run_shaped(40);
        drain_results();
    endtask

    // Bulk random traffic under a few different feed periods.
    task automatic test_random_traffic();
        write_feed_period(PERIOD_W'($urandom_range(PERIOD_MAX, PERIOD_MIN)));
        run_shaped(220);
        write_feed_period(PERIOD_MAX);
        run_shaped(190);
        write_feed_period(PERIOD_W'($urandom_range(100, PERIOD_MIN)));
        run_shaped(200);
        drain_results();
    endtask

    initial begin
        sup_state   = '0;
        feed_period = FEED_PERIOD_RESET;
        clock_ms    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_feed_period();
        test_back_to_back();
        test_backpressure();
        test_random_traffic();

        $display("Checked %0d results from %0d requests: %0d restarts, %0d with the fault set.",
                 n_results, n_requests, n_feeds, n_faulted);
        $display("Feed periods ran from %0d to %0d ms, with a %0d-cycle receiver hold-off.",
                 PERIOD_MIN, PERIOD_MAX, HOLD_CYCLES);
        if (n_fail == 0 && pending_outcomes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
